// ===== src/fbam_pkg.sv =====
// Shared constants, field widths and types for the 3x3 filter bank argmax block.
// No dependencies; fbam_if, fbam_dot and the top level import it.
package fbam_pkg;

    localparam int PIX_W       = 16;
    localparam int COEF_W      = 16;
    localparam int TAPS        = 9;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_FILTERS = 128;
    localparam int COEF_DEPTH  = MAX_FILTERS * TAPS;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int FIDX_W    = $clog2(MAX_FILTERS);
    localparam int CIDX_W    = 11;
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 13;
    localparam int FCNT_W    = 8;
    localparam int MAG_W     = 35;
    localparam int PROD_W    = COEF_W + PIX_W + 1;
    localparam int PSUM_W    = PROD_W + 2;
    localparam int SUM_W     = PROD_W + 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT = 2'd2;

    localparam logic REQ_COEF  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [FIDX_W-1:0] idx;
    } t_dot_ctl;

endpackage

// ===== src/fbam_if.sv =====
// Handshake channels of the filter bank: pixel/coefficient input, result output, config.
// Depends on fbam_pkg.
interface fbam_in_if import fbam_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [PIX_W-1:0]         pixel;

    modport source(output valid, req_type, coef_index, coef_value, pixel, input ready);
    modport sink(input valid, req_type, coef_index, coef_value, pixel, output ready);
endinterface

interface fbam_out_if import fbam_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FIDX_W-1:0] best_filter;
    logic [MAG_W-1:0]  best_magnitude;
    logic [ROW_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;

    modport source(output valid, best_filter, best_magnitude, center_row, center_col,
                   input ready);
    modport sink(input valid, best_filter, best_magnitude, center_row, center_col,
                 output ready);
endinterface

interface fbam_cfg_if import fbam_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== src/fbam_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module fbam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/fbam_dot.sv =====
// Shared dot-product unit: nine multiply lanes, adder tree, magnitude and running argmax.
// Takes one filter per cycle; depends on fbam_pkg.
module fbam_dot import fbam_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dot_ctl          i_ctl,
    input  t_coef             i_coef [TAPS],
    input  t_pix              i_win [TAPS],
    output logic              o_done,
    output logic [FIDX_W-1:0] o_best_idx,
    output logic [MAG_W-1:0]  o_best_mag
);

    t_dot_ctl                 r_c1, r_c2, r_c3, r_c4;
    logic signed [PROD_W-1:0] r_prod [TAPS];
    logic signed [PSUM_W-1:0] r_ps [3];
    logic [MAG_W-1:0]         r_mag;
    logic [FIDX_W-1:0]        r_best_idx;
    logic [MAG_W-1:0]         r_best_mag;
    logic                     r_done;
    logic signed [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]         n_abs;

    always_comb begin
        n_sum = SUM_W'(r_ps[0]) + SUM_W'(r_ps[1]) + SUM_W'(r_ps[2]);
        n_abs = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= '0;
            r_c4   <= '0;
            r_done <= 1'b0;
        end else begin
            r_c1   <= i_ctl;
            r_c2   <= r_c1;
            r_c3   <= r_c2;
            r_c4   <= r_c3;
            r_done <= r_c4.valid && r_c4.last;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < TAPS; t++) begin
            r_prod[t] <= $signed(i_coef[t]) * $signed({1'b0, i_win[t]});
        end
        for (int k = 0; k < 3; k++) begin
            r_ps[k] <= PSUM_W'(r_prod[3*k]) + PSUM_W'(r_prod[3*k+1])
                     + PSUM_W'(r_prod[3*k+2]);
        end
        r_mag <= n_abs[MAG_W-1:0];
        if (r_c3.valid && (r_c3.first || r_mag > r_best_mag)) begin
            r_best_idx <= r_c3.idx;
            r_best_mag <= r_mag;
        end
    end

    assign o_done     = r_done;
    assign o_best_idx = r_best_idx;
    assign o_best_mag = r_best_mag;

endmodule

// ===== src/filter_bank_3x3_argmax.sv =====
// Top level of the 3x3 filter bank argmax: sequencer, coefficient banks, line stores, window.
// Depends on fbam_pkg, fbam_if, fbam_ram and fbam_dot.
//
// A coefficient word is written into its coefficient bank as it is taken. A pixel word that
// does not complete a 3x3 window goes through a line store read, then a window update. A pixel
// word that completes a window then goes to the shared nine-lane multiply unit, which evaluates
// one filter per cycle, fed by nine coefficient banks read in parallel, followed by a five-stage
// drain and the result hand-off. Input ready is low while a pixel is in progress; a finished
// result waits in the output register while the next word is taken. Results leave in pixel
// order, one per window center, with ties resolved to the lowest filter index.
module filter_bank_3x3_argmax import fbam_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    fbam_in_if.sink     i_in,
    fbam_out_if.source  o_out,
    fbam_cfg_if.sink    i_cfg
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LINE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [FCNT_W-1:0]   r_fcount;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_cur_col;
    logic                r_emit;
    logic [ROW_W-1:0]    r_center_row;
    logic [COL_W-1:0]    r_center_col;
    t_pix                r_pix;
    t_pix                r_wc [6];
    t_pix                r_win [TAPS];
    logic [FIDX_W-1:0]   r_f, n_f;
    logic                r_ov;
    logic [FIDX_W-1:0]   r_out_filter;
    logic [MAG_W-1:0]    r_out_mag;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;

    logic                in_acc, pix_acc, coef_acc, load_out;
    logic [WIDTH_W-1:0]  w_lim;
    logic [HEIGHT_W-1:0] h_lim;
    logic [FCNT_W-1:0]   nf_lim;
    logic [FIDX_W-1:0]   nf_last;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic [20:0]         div_prod;
    logic [FIDX_W-1:0]   coef_addr;
    logic [CIDX_W-1:0]   coef_rem;
    logic [3:0]          coef_tap;
    logic                coef_in_range;
    t_pix                up_rd, mid_rd;
    t_coef               coef_rd [TAPS];
    t_dot_ctl            dot_ctl;
    logic                dot_done;
    logic [FIDX_W-1:0]   dot_idx;
    logic [MAG_W-1:0]    dot_mag;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign pix_acc     = in_acc && (i_in.req_type == REQ_PIXEL);
    assign coef_acc    = in_acc && (i_in.req_type == REQ_COEF);

    always_comb begin
        if (r_width < WIDTH_W'(3)) begin
            w_lim = WIDTH_W'(3);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            w_lim = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_lim = r_width;
        end
        if (r_height < HEIGHT_W'(3)) begin
            h_lim = HEIGHT_W'(3);
        end else if (r_height > HEIGHT_W'(MAX_HEIGHT)) begin
            h_lim = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_lim = r_height;
        end
        if (r_fcount < FCNT_W'(1)) begin
            nf_lim = FCNT_W'(1);
        end else if (r_fcount > FCNT_W'(MAX_FILTERS)) begin
            nf_lim = FCNT_W'(MAX_FILTERS);
        end else begin
            nf_lim = r_fcount;
        end
        nf_last = FIDX_W'(nf_lim - FCNT_W'(1));
        col_inc = WIDTH_W'(r_col) + WIDTH_W'(1);
        row_inc = HEIGHT_W'(r_row) + HEIGHT_W'(1);
    end

    // split coefficient index into filter row and tap: q = index / 9 via reciprocal
    always_comb begin
        div_prod      = 21'(i_in.coef_index) * 21'd911;
        coef_addr     = div_prod[13 +: FIDX_W];
        coef_rem      = i_in.coef_index - CIDX_W'(coef_addr) * CIDX_W'(TAPS);
        coef_tap      = coef_rem[3:0];
        coef_in_range = (i_in.coef_index < CIDX_W'(COEF_DEPTH));
    end

    always_comb begin
        n_f = r_f;
        if (r_state == ST_RUN) begin
            n_f = (r_f == nf_last) ? '0 : r_f + FIDX_W'(1);
        end
    end

    for (genvar t = 0; t < TAPS; t++) begin : g_coef
        fbam_ram #(
            .WIDTH (COEF_W),
            .DEPTH (MAX_FILTERS)
        ) u_coef_ram (
            .i_clk     (i_clk),
            .i_wr_en   (coef_acc && coef_in_range && (coef_tap == 4'(t))),
            .i_wr_addr (coef_addr),
            .i_wr_data (i_in.coef_value),
            .i_rd_addr (n_f),
            .o_rd_data (coef_rd[t])
        );
    end

    fbam_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_LINE),
        .i_wr_addr (r_cur_col),
        .i_wr_data (mid_rd),
        .i_rd_addr (r_col),
        .o_rd_data (up_rd)
    );

    fbam_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_LINE),
        .i_wr_addr (r_cur_col),
        .i_wr_data (r_pix),
        .i_rd_addr (r_col),
        .o_rd_data (mid_rd)
    );

    always_comb begin
        dot_ctl.valid = (r_state == ST_RUN);
        dot_ctl.first = (r_f == '0);
        dot_ctl.last  = (r_f == nf_last);
        dot_ctl.idx   = r_f;
    end

    fbam_dot u_dot (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (dot_ctl),
        .i_coef     (coef_rd),
        .i_win      (r_win),
        .o_done     (dot_done),
        .o_best_idx (dot_idx),
        .o_best_mag (dot_mag)
    );

    assign load_out = (r_state == ST_PUSH) && (!r_ov || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (pix_acc) n_state = ST_LINE;
            ST_LINE:  n_state = r_emit ? ST_RUN : ST_IDLE;
            ST_RUN:   if (r_f == nf_last) n_state = ST_DRAIN;
            ST_DRAIN: if (dot_done) n_state = ST_PUSH;
            ST_PUSH:  if (load_out) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_width  <= WIDTH_W'(MAX_WIDTH);
            r_height <= HEIGHT_W'(MAX_HEIGHT);
            r_fcount <= FCNT_W'(MAX_FILTERS);
            r_col    <= '0;
            r_row    <= '0;
            r_emit   <= 1'b0;
            r_f      <= '0;
            r_ov     <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_wc[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg.data[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg.data[HEIGHT_W-1:0];
                    CFG_FILTER_COUNT: r_fcount <= i_cfg.data[FCNT_W-1:0];
                    default: ;
                endcase
            end
            if (pix_acc) begin
                r_emit <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
                if (col_inc >= w_lim) begin
                    r_col <= '0;
                    r_row <= (row_inc >= h_lim) ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    r_col <= col_inc[COL_W-1:0];
                end
            end
            if (r_state == ST_LINE) begin
                r_wc[0] <= r_wc[3];
                r_wc[1] <= r_wc[4];
                r_wc[2] <= r_wc[5];
                r_wc[3] <= up_rd;
                r_wc[4] <= mid_rd;
                r_wc[5] <= r_pix;
            end
            r_f <= n_f;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_pix        <= i_in.pixel;
            r_cur_col    <= r_col;
            r_center_row <= r_row - ROW_W'(1);
            r_center_col <= r_col - COL_W'(1);
        end
        if (r_state == ST_LINE) begin
            r_win[0] <= r_wc[0];
            r_win[1] <= r_wc[3];
            r_win[2] <= up_rd;
            r_win[3] <= r_wc[1];
            r_win[4] <= r_wc[4];
            r_win[5] <= mid_rd;
            r_win[6] <= r_wc[2];
            r_win[7] <= r_wc[5];
            r_win[8] <= r_pix;
        end
        if (load_out) begin
            r_out_filter <= dot_idx;
            r_out_mag    <= dot_mag;
            r_out_row    <= r_center_row;
            r_out_col    <= r_center_col;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.best_filter    = r_out_filter;
    assign o_out.best_magnitude = r_out_mag;
    assign o_out.center_row     = r_out_row;
    assign o_out.center_col     = r_out_col;

endmodule
